/* sv/tad_pkg.sv */
// ============================================================================
// tad_pkg : shared types and constants for the text art detector
// Character classes, configuration layout and the result word.
// ============================================================================
`default_nettype none

package tad_pkg;

    // Default counter width
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port layout
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_RUN        = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_ART_LINES  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_LINE_CHARS = 2'd2;

    // Register reset values
    localparam logic [CFG_DATA_BITS-1:0] MIN_RUN_RST        = 8'd4;
    localparam logic [CFG_DATA_BITS-1:0] MIN_ART_LINES_RST  = 8'd4;
    localparam logic [CFG_DATA_BITS-1:0] MIN_LINE_CHARS_RST = 8'd8;

    // Item kinds carried in tuser
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Special code units
    localparam logic [15:0] CU_LF        = 16'h000a;
    localparam logic [15:0] CU_CR        = 16'h000d;
    localparam logic [15:0] CU_SPACE     = 16'h0020;
    localparam logic [15:0] CU_IDEO_SPACE = 16'h3000;

    // Output field widths
    localparam int OUT_CNT_BITS = 16;
    localparam int OUT_TDATA_BITS = 40;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_ART   = 2'd1,
        CLS_SPACE = 2'd2,
        CLS_BREAK = 2'd3
    } char_class_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] min_run;
        logic [CFG_DATA_BITS-1:0] min_art_lines;
        logic [CFG_DATA_BITS-1:0] min_line_chars;
    } cfg_t;

    typedef struct packed {
        logic [OUT_CNT_BITS-1:0] art_lines;
        logic [OUT_CNT_BITS-1:0] total_lines;
        logic                    is_art;
    } verdict_t;

endpackage

`default_nettype wire

/* sv/tad_classify.sv */
// ============================================================================
// tad_classify : code unit classifier
// Sorts one UTF-16 code unit into art symbol, space, line break or other.
// ============================================================================
`default_nettype none

module tad_classify
    import tad_pkg::*;
(
    input  wire logic [15:0] code_unit,
    output char_class_t      cls
);

    logic art;

    // Fixed range table of art symbols
    always_comb
    begin
        art = 1'b0;
        if ((code_unit >= 16'h0027 && code_unit <= 16'h0029) || code_unit == 16'h002f)
            art = 1'b1;
        else if ((code_unit >= 16'h003a && code_unit <= 16'h003d) ||
                 (code_unit >= 16'h005e && code_unit <= 16'h0060))
            art = 1'b1;
        else if (code_unit >= 16'h007b && code_unit <= 16'h3040)
            art = !(code_unit == CU_IDEO_SPACE ||
                    (code_unit >= 16'h25a0 && code_unit <= 16'h25ff) ||
                    (code_unit >= 16'h3007 && code_unit <= 16'h301c));
        else if ((code_unit >= 16'h3099 && code_unit <= 16'h30a0) ||
                 (code_unit >= 16'h30fb && code_unit <= 16'h30ff))
            art = 1'b1;
        else if ((code_unit >= 16'h3100 && code_unit <= 16'h33ff) ||
                 (code_unit >= 16'h4dc0 && code_unit <= 16'h4dff))
            art = 1'b1;
        else if (code_unit <= 16'h9fff)
            art = 1'b0;
        else if (code_unit <= 16'hfeff)
            art = 1'b1;
        else
            art = (code_unit >= 16'hff07 && code_unit <= 16'hff0f) ||
                  (code_unit >= 16'hff1a && code_unit <= 16'hff1e) ||
                  (code_unit >= 16'hff3b && code_unit <= 16'hff40) ||
                  (code_unit >= 16'hff5b && code_unit <= 16'hff65) ||
                  (code_unit >= 16'hff9e);
    end

    // Breaks and spaces take precedence over the table
    always_comb
    begin
        if (code_unit == CU_CR || code_unit == CU_LF)
            cls = CLS_BREAK;
        else if (code_unit == CU_SPACE || code_unit == CU_IDEO_SPACE)
            cls = CLS_SPACE;
        else if (art)
            cls = CLS_ART;
        else
            cls = CLS_OTHER;
    end

endmodule

`default_nettype wire

/* sv/tad_tracker.sv */
// ============================================================================
// tad_tracker : line and text statistics
// Keeps per-line run and character counts, closes lines, and forms the
// verdict when the end-of-text word arrives.
// ============================================================================
`default_nettype none

module tad_tracker
    import tad_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,       // registered word advances this cycle
    input  wire logic        is_end,
    input  wire char_class_t cls,
    input  wire cfg_t        cfg,
    output verdict_t         verdict
);

    localparam int CW = COUNT_BITS;
    localparam int WW = COUNT_BITS + 2;
    localparam int XW = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    logic [CW-1:0] best_run_reg,   best_run_next;
    logic [CW-1:0] cur_run_reg,    cur_run_next;
    logic [CW-1:0] line_chars_reg, line_chars_next;
    logic [CW-1:0] art_chars_reg,  art_chars_next;
    logic [CW-1:0] plain_chars_reg, plain_chars_next;
    logic [CW-1:0] lines_reg,      lines_next;
    logic [CW-1:0] art_lines_reg,  art_lines_next;

    logic          line_is_art;
    logic [CW-1:0] closed_lines;
    logic [CW-1:0] closed_art;
    logic [CW-1:0] run_inc;
    logic [XW-1:0] tot_x;
    logic [XW-1:0] art_x;

    // Line closing: art-line test and counter bumps
    always_comb
    begin
        line_is_art = (best_run_reg >= CW'(cfg.min_run)) ||
                      ((line_chars_reg >= CW'(cfg.min_line_chars)) &&
                       (art_chars_reg >= plain_chars_reg));
        closed_lines = sat_inc(lines_reg);
        closed_art   = line_is_art ? sat_inc(art_lines_reg) : art_lines_reg;
        run_inc      = sat_inc(cur_run_reg);
    end

    // Next state per word
    always_comb
    begin
        best_run_next    = best_run_reg;
        cur_run_next     = cur_run_reg;
        line_chars_next  = line_chars_reg;
        art_chars_next   = art_chars_reg;
        plain_chars_next = plain_chars_reg;
        lines_next       = lines_reg;
        art_lines_next   = art_lines_reg;
        if (is_end)
        begin
            best_run_next    = '0;
            cur_run_next     = '0;
            line_chars_next  = '0;
            art_chars_next   = '0;
            plain_chars_next = '0;
            lines_next       = '0;
            art_lines_next   = '0;
        end
        else
        begin
            case (cls)
                CLS_BREAK:
                begin
                    best_run_next    = '0;
                    cur_run_next     = '0;
                    line_chars_next  = '0;
                    art_chars_next   = '0;
                    plain_chars_next = '0;
                    lines_next       = closed_lines;
                    art_lines_next   = closed_art;
                end
                CLS_ART:
                begin
                    cur_run_next    = run_inc;
                    art_chars_next  = sat_inc(art_chars_reg);
                    line_chars_next = sat_inc(line_chars_reg);
                    if (best_run_reg < run_inc)
                        best_run_next = run_inc;
                end
                CLS_SPACE:
                begin
                    line_chars_next = sat_inc(line_chars_reg);
                end
                default:
                begin
                    cur_run_next     = '0;
                    plain_chars_next = sat_inc(plain_chars_reg);
                    line_chars_next  = sat_inc(line_chars_reg);
                end
            endcase
        end
    end

    // Verdict from the counts after the last line closes
    always_comb
    begin
        verdict.is_art =
            ((closed_art >= CW'(cfg.min_art_lines)) &&
             ({closed_art, 2'b00} > WW'(closed_lines))) ||
            ((closed_lines > CW'(3'd4)) &&
             ({1'b0, closed_art, 1'b0} > WW'(closed_lines)));
        tot_x = XW'(closed_lines);
        art_x = XW'(closed_art);
        verdict.total_lines = (tot_x > XW'({OUT_CNT_BITS{1'b1}})) ?
                              {OUT_CNT_BITS{1'b1}} : tot_x[OUT_CNT_BITS-1:0];
        verdict.art_lines   = (art_x > XW'({OUT_CNT_BITS{1'b1}})) ?
                              {OUT_CNT_BITS{1'b1}} : art_x[OUT_CNT_BITS-1:0];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_run_reg    <= '0;
            cur_run_reg     <= '0;
            line_chars_reg  <= '0;
            art_chars_reg   <= '0;
            plain_chars_reg <= '0;
            lines_reg       <= '0;
            art_lines_reg   <= '0;
        end
        else if (step)
        begin
            best_run_reg    <= best_run_next;
            cur_run_reg     <= cur_run_next;
            line_chars_reg  <= line_chars_next;
            art_chars_reg   <= art_chars_next;
            plain_chars_reg <= plain_chars_next;
            lines_reg       <= lines_next;
            art_lines_reg   <= art_lines_next;
        end
    end

endmodule

`default_nettype wire

/* sv/text_art_detector_unit.sv */
// ============================================================================
// text_art_detector_unit : character art detector
// Streams UTF-16 code units and judges whether the text is character art.
// ============================================================================
// One word per cycle is taken on the input stream: tuser = 0 carries a code
// unit, tuser = 1 marks end of text. Each word is classified on entry and
// lands in an input register; from there it updates the line counters
// in a single pass, so the sustained rate is one word per clock. The
// end-of-text word yields one result word, registered from the tracker
// into an output register; character words keep flowing while that
// result waits, and the input only stalls when a second end-of-text word
// reaches the tracker before the first result is taken. Counters saturate
// at 2^COUNT_BITS - 1. Configuration writes belong to idle periods.
// ============================================================================
`default_nettype none

module text_art_detector_unit
    import tad_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration write port
    input  wire logic                      cfg_wen,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    // input stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [15:0]               s_axis_tdata,  // [15:0] code_unit
    input  wire logic                      s_axis_tuser,  // [0] action
    // result stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata   // [0] is_art,
                                                          // [16:1] total_lines,
                                                          // [32:17] art_lines
);

    cfg_t        cfg_reg;
    logic        in_valid_reg, in_valid_next;
    logic        in_end_reg;
    char_class_t in_cls_reg;
    char_class_t cls_in;
    logic        advance;
    logic        load_out;
    logic        out_valid_reg, out_valid_next;
    verdict_t    out_reg;
    verdict_t    verdict;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_run        <= MIN_RUN_RST;
            cfg_reg.min_art_lines  <= MIN_ART_LINES_RST;
            cfg_reg.min_line_chars <= MIN_LINE_CHARS_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_MIN_RUN:        cfg_reg.min_run        <= cfg_data;
                REG_MIN_ART_LINES:  cfg_reg.min_art_lines  <= cfg_data;
                REG_MIN_LINE_CHARS: cfg_reg.min_line_chars <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify on entry
    tad_classify u_classify (
        .code_unit (s_axis_tdata),
        .cls       (cls_in)
    );

    // Input stage: only an end word facing a full output register stalls
    always_comb
    begin
        advance       = in_valid_reg &&
                        !(in_end_reg && out_valid_reg && !m_axis_tready);
        s_axis_tready = !in_valid_reg || advance;
        load_out      = advance && in_end_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_end_reg <= (s_axis_tuser == ACT_END);
            in_cls_reg <= cls_in;
        end
    end

    // Line and text statistics
    tad_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .is_end  (in_end_reg),
        .cls     (in_cls_reg),
        .cfg     (cfg_reg),
        .verdict (verdict)
    );

    // Output register
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= verdict;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_BITS'(out_reg);

    // Checks
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_axis_tvalid)
        else $error("end word did not produce a result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_art_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_reg.art_lines <= out_reg.total_lines))
        else $error("art line count exceeds total line count");

    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_reg.total_lines != '0))
        else $error("result with zero lines");

endmodule

`default_nettype wire

/* test/text_art_detector_unit_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// text_art_detector_unit_tb : self-checking bench for the text art detector
// Streams directed and random texts through the detector under several
// handshake idling patterns and register settings. A behavioral tracker
// predicts all but typed-in verdicts; each result word is compared field by field.
// ============================================================================

module text_art_detector_unit_tb;
    import tad_pkg::*;

    // index that maps to no register; writes to it must change nothing
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          MAX_REPORTS    = 10;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          DIR_ROWS       = 25;
    localparam logic [15:0] CNT_TOP        = 16'hffff;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wen;
    logic [CFG_IDX_BITS-1:0]      cfg_index;
    logic [CFG_DATA_BITS-1:0]     cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [15:0]                  s_axis_tdata;   // [15:0] code_unit
    logic                         s_axis_tuser;   // [0] action
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [OUT_TDATA_BITS-1:0]    m_axis_tdata;   // [0] is_art, [16:1] total_lines,
                                                  // [32:17] art_lines

    text_art_detector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Line tracker: mirrors the detector state word by word
    // ------------------------------------------------------------------------
    cfg_t        thr;
    logic [15:0] run_best;
    logic [15:0] run_now;
    logic [15:0] chars_in_line;
    logic [15:0] art_in_line;
    logic [15:0] plain_in_line;
    logic [15:0] lines_total;
    logic [15:0] lines_art;

    verdict_t    verdict_q[$];
    int          mismatches;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          words_sent;
    int          ends_sent;
    int          quiet_cycles;

    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == CNT_TOP) ? v : v + 16'd1;
    endfunction

    function automatic bit in_span(input logic [15:0] c, input logic [15:0] lo,
                                   input logic [15:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // symbol table; spaces are filtered out before this is asked
    function automatic bit art_symbol(input logic [15:0] c);
        if (in_span(c, 16'h0027, 16'h0029) || c == 16'h002f)
            return 1'b1;
        if (in_span(c, 16'h003a, 16'h003d) || in_span(c, 16'h005e, 16'h0060))
            return 1'b1;
        // wide symbol block with three holes
        if (in_span(c, 16'h007b, 16'h3040))
            return !(c == 16'h3000 || in_span(c, 16'h25a0, 16'h25ff) ||
                     in_span(c, 16'h3007, 16'h301c));
        if (in_span(c, 16'h3099, 16'h30a0) || in_span(c, 16'h30fb, 16'h33ff))
            return 1'b1;
        if (in_span(c, 16'h4dc0, 16'h4dff) || in_span(c, 16'ha000, 16'hfeff))
            return 1'b1;
        // half and full width forms
        return in_span(c, 16'hff07, 16'hff0f) || in_span(c, 16'hff1a, 16'hff1e) ||
               in_span(c, 16'hff3b, 16'hff40) || in_span(c, 16'hff5b, 16'hff65) ||
               in_span(c, 16'hff9e, 16'hffff);
    endfunction

    function automatic char_class_t classify(input logic [15:0] c);
        if (c == CU_CR || c == CU_LF)
            return CLS_BREAK;
        if (c == CU_SPACE || c == CU_IDEO_SPACE)
            return CLS_SPACE;
        return art_symbol(c) ? CLS_ART : CLS_OTHER;
    endfunction

    task automatic clear_line();
        run_best      = '0;
        run_now       = '0;
        chars_in_line = '0;
        art_in_line   = '0;
        plain_in_line = '0;
    endtask

    task automatic clear_text();
        clear_line();
        lines_total = '0;
        lines_art   = '0;
    endtask

    task automatic close_line();
        if (run_best >= thr.min_run ||
            (chars_in_line >= thr.min_line_chars && art_in_line >= plain_in_line))
            lines_art = sat_up(lines_art);
        lines_total = sat_up(lines_total);
        clear_line();
    endtask

    // advance the tracker by one accepted word
    task automatic track_word(input logic act, input logic [15:0] cu,
                              output bit has_res, output verdict_t res);
        int t;
        int a;
        has_res = 1'b0;
        res     = '0;
        if (act == ACT_CHAR)
        begin
            case (classify(cu))
                CLS_BREAK:
                    close_line();
                CLS_ART:
                begin
                    run_now     = sat_up(run_now);
                    art_in_line = sat_up(art_in_line);
                    if (run_best < run_now)
                        run_best = run_now;
                    chars_in_line = sat_up(chars_in_line);
                end
                CLS_SPACE:
                    chars_in_line = sat_up(chars_in_line);
                default:
                begin
                    run_now       = '0;
                    plain_in_line = sat_up(plain_in_line);
                    chars_in_line = sat_up(chars_in_line);
                end
            endcase
        end
        else
        begin
            close_line();
            t = lines_total;
            a = lines_art;
            res.is_art      = (a >= int'(thr.min_art_lines) && 4 * a > t) ||
                              (t > 4 && 2 * a > t);
            res.total_lines = lines_total;
            res.art_lines   = lines_art;
            has_res         = 1'b1;
            clear_text();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_word(input logic act, input logic [15:0] cu,
                             input bit typed, input verdict_t typed_res);
        bit       has_res;
        verdict_t res;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cu;
        s_axis_tuser  <= act;
        do @(posedge clk); while (!s_axis_tready);
        track_word(act, cu, has_res, res);
        if (has_res)
            verdict_q.push_back(typed ? typed_res : res);
        words_sent++;
        if (act == ACT_END)
            ends_sent++;
    endtask

    // hold off until every verdict is back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three thresholds plus the unmapped index
    task automatic apply_settings(input logic [7:0] run_v, input logic [7:0] arts_v,
                                  input logic [7:0] chars_v);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_MIN_RUN;
        cfg_data  <= run_v;
        @(posedge clk);
        cfg_index <= REG_MIN_ART_LINES;
        cfg_data  <= arts_v;
        @(posedge clk);
        cfg_index <= REG_MIN_LINE_CHARS;
        cfg_data  <= chars_v;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= 8'($urandom_range(0, 255));
        @(posedge clk);
        cfg_wen <= 1'b0;
        thr.min_run        = run_v;
        thr.min_art_lines  = arts_v;
        thr.min_line_chars = chars_v;
    endtask

    // one code unit for a line; art_pct steers the symbol share
    function automatic logic [15:0] pick_unit(input int art_pct);
        logic [15:0] c;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 16'($urandom_range(0, 65535));
        if (r < 12)
            return $urandom_range(0, 1) ? CU_SPACE : CU_IDEO_SPACE;
        if ($urandom_range(0, 99) < art_pct)
        begin
            if ($urandom_range(0, 1))
            begin
                do c = 16'($urandom_range(0, 65535)); while (classify(c) != CLS_ART);
                return c;
            end
            case ($urandom_range(0, 4))
                0:       return 16'h0027 + 16'($urandom_range(0, 2));
                1:       return 16'h002f;
                2:       return 16'h003a + 16'($urandom_range(0, 3));
                3:       return 16'h005e + 16'($urandom_range(0, 2));
                default: return 16'h30fb + 16'($urandom_range(0, 4));
            endcase
        end
        // plain text: letters, digits, ideographs
        case ($urandom_range(0, 2))
            0:       return 16'h0061 + 16'($urandom_range(0, 25));
            1:       return 16'h0030 + 16'($urandom_range(0, 9));
            default: return 16'h4e00 + 16'($urandom_range(0, 16'h51ff));
        endcase
    endfunction

    // one random text: mostly well formed lines, sometimes raw noise
    task automatic send_text();
        int n_lines;
        int len;
        int art_pct;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 15))
                send_word(($urandom_range(0, 7) == 0) ? ACT_END : ACT_CHAR,
                          16'($urandom_range(0, 65535)), 1'b0, '0);
        end
        else
        begin
            n_lines = $urandom_range(1, 7);
            case ($urandom_range(0, 2))
                0:       art_pct = 20;
                1:       art_pct = 50;
                default: art_pct = 85;
            endcase
            for (int i = 0; i < n_lines; i++)
            begin
                len = $urandom_range(0, 10);
                for (int j = 0; j < len; j++)
                    send_word(ACT_CHAR, pick_unit(art_pct), 1'b0, '0);
                if (i < n_lines - 1 || $urandom_range(0, 5) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            send_word(ACT_CHAR, CU_CR, 1'b0, '0);
                            send_word(ACT_CHAR, CU_LF, 1'b0, '0);
                        end
                        1:       send_word(ACT_CHAR, CU_CR, 1'b0, '0);
                        default: send_word(ACT_CHAR, CU_LF, 1'b0, '0);
                    endcase
                end
            end
        end
        send_word(ACT_END, 16'($urandom_range(0, 65535)), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: ready pattern and result check
    // ------------------------------------------------------------------------
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    task automatic report(input string what, input verdict_t want, input verdict_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch (%s): expected art=%0b total=%0d arts=%0d, %s",
                     $realtime, what, want.is_art, want.total_lines, want.art_lines,
                     $sformatf("got art=%0b total=%0d arts=%0d",
                               got.is_art, got.total_lines, got.art_lines));
    endtask

    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = verdict_t'(m_axis_tdata[$bits(verdict_t)-1:0]);
            if (verdict_q.size() == 0)
                report("unexpected word", '0, got);
            else
            begin
                want = verdict_q.pop_front();
                if (got.is_art != want.is_art || got.total_lines != want.total_lines ||
                    got.art_lines != want.art_lines)
                    report("field", want, got);
            end
        end
    end

    // Watchdog: no word moving on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed words: expected verdict typed in where it is obvious
    // ------------------------------------------------------------------------
    typedef struct {
        logic        act;
        logic [15:0] cu;
        bit          typed;
        logic        is_art;
        logic [15:0] total;
        logic [15:0] arts;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS];

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        verdict_t typed_res;
        int       base_w;
        int       base_e;

        rst_n          = 1'b0;
        cfg_wen        = 1'b0;
        cfg_index      = REG_MIN_RUN;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_CHAR;
        m_axis_tready  = 1'b0;
        mismatches     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        words_sent     = 0;
        ends_sent      = 0;
        quiet_cycles   = 0;
        thr.min_run        = MIN_RUN_RST;
        thr.min_art_lines  = MIN_ART_LINES_RST;
        thr.min_line_chars = MIN_LINE_CHARS_RST;
        clear_text();

        dir_rows = '{
            '{ACT_END,  16'hffff, 1'b1, 1'b0, 16'd1, 16'd0},  // empty text
            '{ACT_END,  CU_CR,    1'b1, 1'b0, 16'd1, 16'd0},  // code unit ignored at end
            '{ACT_CHAR, 16'h0000, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'hffff, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'h0027, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'h0029, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'h002f, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, CU_IDEO_SPACE, 1'b0, 1'b0, 16'd0, 16'd0},  // space inside a run
            '{ACT_CHAR, CU_SPACE, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'h007b, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'h25a0, 1'b0, 1'b0, 16'd0, 16'd0},  // hole in symbol block
            '{ACT_CHAR, 16'h3040, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, CU_CR,    1'b0, 1'b0, 16'd0, 16'd0},  // CR LF closes two lines
            '{ACT_CHAR, CU_LF,    1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'h4dc0, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'h9fff, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'ha000, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'hff9e, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, 16'h301c, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_END,  16'h0000, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, CU_CR,    1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_CHAR, CU_LF,    1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_END,  16'h5a5a, 1'b1, 1'b0, 16'd3, 16'd0},  // three empty lines
            '{ACT_CHAR, 16'hff66, 1'b0, 1'b0, 16'd0, 16'd0},
            '{ACT_END,  16'h0000, 1'b0, 1'b0, 16'd0, 16'd0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset thresholds, no idling
        foreach (dir_rows[i])
        begin
            typed_res.is_art      = dir_rows[i].is_art;
            typed_res.total_lines = dir_rows[i].total;
            typed_res.art_lines   = dir_rows[i].arts;
            send_word(dir_rows[i].act, dir_rows[i].cu, dir_rows[i].typed, typed_res);
        end

        // random texts, one idling pattern and threshold set per phase
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:
                begin
                    settle();
                    apply_settings(8'd1, 8'd1, 8'd1);
                    src_idle_pct   = 50;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    settle();
                    apply_settings(8'd255, 8'd255, 8'd255);
                    src_idle_pct   = 0;
                    sink_stall_pct = 50;
                end
                3:
                begin
                    settle();
                    apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
                    src_idle_pct   = 28;
                    sink_stall_pct = 28;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            base_w = words_sent;
            base_e = ends_sent;
            while (words_sent - base_w < 105 || ends_sent - base_e < 4)
            begin
                send_text();
                if ($urandom_range(0, 7) == 0)
                    wait_drain();
            end
        end

        settle();
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
